// ===== rtl/mmk_pkg.sv =====
// Shared types, codes and the dit length table for the memory keyer.
// No dependencies; every other file except mmk_rsp_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package mmk_pkg;

   // Operating modes as shown on the result channel.
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_REC    = 2'd1,
      MODE_PROMPT = 2'd2,
      MODE_PLAY   = 2'd3
   } mmk_mode_type;

   // Paddle keyer phases.
   typedef enum logic [1:0] {
      KEY_IDLE  = 2'd0,
      KEY_SEND  = 2'd1,
      KEY_SPACE = 2'd2
   } mmk_key_type;

   // Element codes kept in the sequence memory.
   localparam logic [1:0] CODE_DIT      = 2'd0;
   localparam logic [1:0] CODE_DAH      = 2'd1;
   localparam logic [1:0] CODE_GAP      = 2'd2;
   localparam logic [1:0] CODE_WORD_GAP = 2'd3;

   localparam int unsigned UNIT_WIDTH  = 8;
   localparam int unsigned TIMER_WIDTH = 11;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
   localparam int unsigned PROMPT_WIDTH   = 16;
   localparam int unsigned DEBOUNCE_WIDTH = 10;
   localparam int unsigned WPM_WIDTH      = 6;
   localparam int unsigned SLOT_BUTTONS   = 4;

   // Register indexes of the configuration port.
   localparam logic CSR_SAVE_TIMEOUT = 1'b0;
   localparam logic CSR_DEBOUNCE     = 1'b1;

   // Dit length in ticks, 1200 / wpm, with the speed held to 5..40.
   function automatic logic [UNIT_WIDTH-1:0] unit_for_wpm(input logic [WPM_WIDTH-1:0] wpm);
      logic [UNIT_WIDTH-1:0] unit;
      unique case (wpm)
         6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: unit = 8'd240;
         6'd6:  unit = 8'd200;
         6'd7:  unit = 8'd171;
         6'd8:  unit = 8'd150;
         6'd9:  unit = 8'd133;
         6'd10: unit = 8'd120;
         6'd11: unit = 8'd109;
         6'd12: unit = 8'd100;
         6'd13: unit = 8'd92;
         6'd14: unit = 8'd85;
         6'd15: unit = 8'd80;
         6'd16: unit = 8'd75;
         6'd17: unit = 8'd70;
         6'd18: unit = 8'd66;
         6'd19: unit = 8'd63;
         6'd20: unit = 8'd60;
         6'd21: unit = 8'd57;
         6'd22: unit = 8'd54;
         6'd23: unit = 8'd52;
         6'd24: unit = 8'd50;
         6'd25: unit = 8'd48;
         6'd26: unit = 8'd46;
         6'd27: unit = 8'd44;
         6'd28: unit = 8'd42;
         6'd29: unit = 8'd41;
         6'd30: unit = 8'd40;
         6'd31: unit = 8'd38;
         6'd32: unit = 8'd37;
         6'd33: unit = 8'd36;
         6'd34: unit = 8'd35;
         6'd35: unit = 8'd34;
         6'd36: unit = 8'd33;
         6'd37: unit = 8'd32;
         6'd38: unit = 8'd31;
         default: unit = 8'd30;
      endcase
      return unit;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mmk_req_if.sv =====
// Tick transaction channel carrying paddle, button and speed levels.
// Depends on mmk_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mmk_req_if
   import mmk_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic                       dit_paddle;
   logic                       dah_paddle;
   logic                       record_button;
   logic [SLOT_BUTTONS-1:0]    slot_buttons;
   logic [WPM_WIDTH-1:0]       speed_wpm;

   modport source (output valid, dit_paddle, dah_paddle, record_button, slot_buttons,
                   speed_wpm, input ready);
   modport sink   (input valid, dit_paddle, dah_paddle, record_button, slot_buttons,
                   speed_wpm, output ready);
endinterface

`default_nettype wire

// ===== rtl/mmk_rsp_if.sv =====
// Result transaction channel carrying tone, lamp and mode levels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mmk_rsp_if;
   logic       valid;
   logic       ready;
   logic       tone;
   logic       led;
   logic [1:0] mode;

   modport source (output valid, tone, led, mode, input ready);
   modport sink   (input valid, tone, led, mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/morse_memory_keyer_unit.sv =====
// Morse memory keyer: paddle keyer, recorder and four-slot replay per tick.
// Depends on mmk_pkg, mmk_req_if and mmk_rsp_if.
//
//   channel   direction  contents
//   req_ch    in         dit, dah, record, slot buttons, speed (one tick)
//   rsp_ch    out        tone, led, mode (one per tick)
//   csr_*     in         save timeout, debounce length
//
// A tick passes through ST_ACCEPT, ST_BUTTON, ST_ACTION and ST_FINISH, and through
// ST_PLAY while replaying, since the stored code is read from the sequence memory into a register.
// The result register lets the next tick be taken while a result waits;
// a tick finishes only once the previous result has been taken.
// Reset clears all control state; the sequence memory needs no clearing,
// since slots are reached only through their recorded lengths.
`timescale 1ns / 1ps
`default_nettype none

module morse_memory_keyer_unit
   import mmk_pkg::*;
#(
   parameter int unsigned SLOT_COUNT    = 4,
   parameter int unsigned SLOT_CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mmk_req_if.sink          req_ch,
   mmk_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int unsigned NW = $clog2(SLOT_COUNT + 1);
   localparam int unsigned IW = $clog2(SLOT_CAPACITY);
   localparam int unsigned LW = $clog2(SLOT_CAPACITY + 1);
   localparam int unsigned AW = NW + IW;
   localparam int unsigned MEM_DEPTH = (SLOT_COUNT + 1) << IW;
   localparam int unsigned NB = (SLOT_COUNT < SLOT_BUTTONS) ? SLOT_COUNT : SLOT_BUTTONS;
   localparam logic [LW-1:0] CAP = LW'(SLOT_CAPACITY);

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_BUTTON,
      ST_ACTION,
      ST_PLAY,
      ST_FINISH
   } state_type;

   // Control and timing registers.
   state_type                 state_ff, state_in;
   mmk_mode_type              mode_ff, mode_in;
   mmk_key_type               key_ff, key_in;
   logic                      last_dit_ff, last_dit_in;
   logic [TIMER_WIDTH-1:0]    timer_ff, timer_in;
   logic [SW-1:0]             play_slot_ff, play_slot_in;
   logic [NW-1:0]             play_buf_ff, play_buf_in;
   logic [LW-1:0]             play_len_ff, play_len_in;
   logic [LW-1:0]             play_idx_ff, play_idx_in;
   logic                      tone_on_ff, tone_on_in;
   logic [PROMPT_WIDTH-1:0]   prompt_ff, prompt_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;
   logic [SW-1:0]             last_slot_ff, last_slot_in;
   logic [LW-1:0]             rec_len_ff, rec_len_in;
   logic [NW-1:0]             rec_buf_ff, rec_buf_in;
   logic [LW-1:0]             slot_len_ff [SLOT_COUNT];
   logic [LW-1:0]             slot_len_in [SLOT_COUNT];
   logic [NW-1:0]             slot_buf_ff [SLOT_COUNT];
   logic [NW-1:0]             slot_buf_in [SLOT_COUNT];
   logic [PROMPT_WIDTH-1:0]   save_timeout_ff;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ticks_ff;

   // Captured tick fields.
   logic                      dit_ff, dit_in;
   logic                      dah_ff, dah_in;
   logic                      rec_btn_ff, rec_btn_in;
   logic [SLOT_BUTTONS-1:0]   slots_ff, slots_in;
   logic [UNIT_WIDTH-1:0]     unit_ff, unit_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_tone_ff, rsp_tone_in;
   logic                      rsp_led_ff, rsp_led_in;
   logic [1:0]                rsp_mode_ff, rsp_mode_in;

   // Sequence memory: one buffer per slot plus the recording buffer.
   logic [1:0]                seq_mem [MEM_DEPTH];
   logic [1:0]                rd_data_ff;
   logic [AW-1:0]             rd_addr;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [1:0]                mem_wdata;

   logic [TIMER_WIDTH-1:0]    unit_w;
   logic [TIMER_WIDTH-1:0]    target;
   logic [TIMER_WIDTH-1:0]    dur;
   logic                      seen;
   logic                      log_en;
   logic [1:0]                log_code;

   assign req_ch.ready = (state_ff == ST_ACCEPT);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.tone  = rsp_tone_ff;
   assign rsp_ch.led   = rsp_led_ff;
   assign rsp_ch.mode  = rsp_mode_ff;

   assign unit_w  = TIMER_WIDTH'(unit_ff);
   assign rd_addr = {play_buf_ff, play_idx_ff[IW-1:0]};

   // Next-state logic of the tick sequencer.
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      last_dit_in  = last_dit_ff;
      timer_in     = timer_ff;
      play_slot_in = play_slot_ff;
      play_buf_in  = play_buf_ff;
      play_len_in  = play_len_ff;
      play_idx_in  = play_idx_ff;
      tone_on_in   = tone_on_ff;
      prompt_in    = prompt_ff;
      debounce_in  = debounce_ff;
      last_slot_in = last_slot_ff;
      rec_len_in   = rec_len_ff;
      rec_buf_in   = rec_buf_ff;
      slot_len_in  = slot_len_ff;
      slot_buf_in  = slot_buf_ff;
      dit_in       = dit_ff;
      dah_in       = dah_ff;
      rec_btn_in   = rec_btn_ff;
      slots_in     = slots_ff;
      unit_in      = unit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_tone_in  = rsp_tone_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_mode_in  = rsp_mode_ff;
      seen         = 1'b0;
      log_en       = 1'b0;
      log_code     = CODE_DIT;
      target       = unit_w;
      dur          = unit_w;

      unique case (state_ff)
         // Take a tick transaction and look up the dit length.
         ST_ACCEPT: begin
            if (req_ch.valid) begin
               dit_in     = req_ch.dit_paddle;
               dah_in     = req_ch.dah_paddle;
               rec_btn_in = req_ch.record_button;
               slots_in   = req_ch.slot_buttons;
               unit_in    = unit_for_wpm(req_ch.speed_wpm);
               state_in   = ST_BUTTON;
            end
         end

         // Prompt timer and debounce count, then record button and slot buttons in ascending order.
         ST_BUTTON: begin
            if (mode_ff == MODE_PROMPT && prompt_ff != '1) begin
               prompt_in = prompt_ff + 1'b1;
            end
            if (debounce_ff != '0) begin
               debounce_in = debounce_ff - 1'b1;
            end else begin
               if (rec_btn_ff) begin
                  seen = 1'b1;
                  if (mode_in == MODE_IDLE) begin
                     rec_len_in = '0;
                     mode_in    = MODE_REC;
                  end else if (mode_in == MODE_REC) begin
                     mode_in   = MODE_PROMPT;
                     prompt_in = '0;
                  end
               end
               for (int i = 0; i < NB; i++) begin
                  if (slots_ff[i]) begin
                     seen = 1'b1;
                     priority if (mode_in == MODE_PROMPT) begin
                        // Save: the recording buffer becomes this slot's buffer.
                        slot_len_in[i] = rec_len_in;
                        rec_buf_in     = slot_buf_in[i];
                        slot_buf_in[i] = rec_buf_ff;
                        last_slot_in   = SW'(i);
                        mode_in        = MODE_IDLE;
                     end else if (mode_in == MODE_IDLE) begin
                        if (slot_len_in[i] != '0) begin
                           play_slot_in = SW'(i);
                           play_buf_in  = slot_buf_in[i];
                           play_len_in  = slot_len_in[i];
                           play_idx_in  = '0;
                           timer_in     = '0;
                           tone_on_in   = 1'b0;
                           mode_in      = MODE_PLAY;
                        end
                     end else if (mode_in == MODE_PLAY && play_slot_in == SW'(i)) begin
                        mode_in    = MODE_IDLE;
                        tone_on_in = 1'b0;
                     end else begin
                        mode_in = mode_in;
                     end
                  end
               end
               if (seen) begin
                  debounce_in = debounce_ticks_ff;
               end
            end
            state_in = ST_ACTION;
         end

         // Action of the mode now in force.
         ST_ACTION: begin
            state_in = ST_FINISH;
            unique case (mode_ff)
               MODE_IDLE, MODE_REC: begin
                  unique case (key_ff)
                     KEY_IDLE: begin
                        if (dit_ff || dah_ff) begin
                           key_in      = KEY_SEND;
                           timer_in    = TIMER_WIDTH'(1);
                           last_dit_in = dit_ff;
                           log_en      = 1'b1;
                           log_code    = dit_ff ? CODE_DIT : CODE_DAH;
                        end
                     end
                     KEY_SEND: begin
                        target = last_dit_ff ? unit_w : unit_w * TIMER_WIDTH'(3);
                        if (timer_ff >= target) begin
                           key_in   = KEY_SPACE;
                           timer_in = TIMER_WIDTH'(1);
                           log_en   = 1'b1;
                           log_code = CODE_GAP;
                        end else if (timer_ff != TIMER_MAX) begin
                           timer_in = timer_ff + 1'b1;
                        end
                     end
                     KEY_SPACE: begin
                        if (timer_ff >= unit_w) begin
                           key_in = KEY_IDLE;
                        end else if (timer_ff != TIMER_MAX) begin
                           timer_in = timer_ff + 1'b1;
                        end
                     end
                     default: key_in = KEY_IDLE;
                  endcase
                  if (mode_ff == MODE_REC) begin
                     if (log_en && rec_len_ff < CAP) begin
                        rec_len_in = rec_len_ff + 1'b1;
                     end
                     if (rec_len_in >= CAP) begin
                        mode_in   = MODE_PROMPT;
                        prompt_in = '0;
                     end
                  end
               end
               MODE_PROMPT: begin
                  if (prompt_ff >= save_timeout_ff) begin
                     for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (last_slot_ff == SW'(i)) begin
                           slot_len_in[i] = rec_len_ff;
                           slot_buf_in[i] = rec_buf_ff;
                           rec_buf_in     = slot_buf_ff[i];
                        end
                     end
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_PLAY: begin
                  state_in = ST_PLAY;
               end
               default: mode_in = MODE_IDLE;
            endcase
         end

         // Replay step on the code read from the slot's buffer.
         ST_PLAY: begin
            if (play_idx_ff >= play_len_ff) begin
               mode_in    = MODE_IDLE;
               tone_on_in = 1'b0;
            end else begin
               unique case (rd_data_ff)
                  CODE_DAH:      dur = unit_w * TIMER_WIDTH'(3);
                  CODE_WORD_GAP: dur = unit_w * TIMER_WIDTH'(7);
                  default:       dur = unit_w;
               endcase
               if ((rd_data_ff == CODE_DIT || rd_data_ff == CODE_DAH) && !tone_on_ff) begin
                  tone_on_in = 1'b1;
                  timer_in   = TIMER_WIDTH'(1);
               end else if (timer_ff >= dur) begin
                  tone_on_in  = 1'b0;
                  play_idx_in = play_idx_ff + 1'b1;
                  timer_in    = TIMER_WIDTH'(1);
               end else if (timer_ff != TIMER_MAX) begin
                  timer_in = timer_ff + 1'b1;
               end
            end
            state_in = ST_FINISH;
         end

         // Load the result register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_led_in   = (mode_ff == MODE_REC);
               rsp_mode_in  = mode_ff;
               unique case (mode_ff)
                  MODE_IDLE, MODE_REC: rsp_tone_in = (key_ff == KEY_SEND);
                  MODE_PLAY:           rsp_tone_in = tone_on_ff;
                  default:             rsp_tone_in = 1'b0;
               endcase
               state_in = ST_ACCEPT;
            end
         end

         default: state_in = ST_ACCEPT;
      endcase
   end

   // Recording writes go to the current recording buffer.
   assign mem_we    = (state_ff == ST_ACTION) && (mode_ff == MODE_REC) && log_en
                      && (rec_len_ff < CAP);
   assign mem_waddr = {rec_buf_ff, rec_len_ff[IW-1:0]};
   assign mem_wdata = log_code;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seq_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= seq_mem[rd_addr];
   end

   // State, timers, slot map, configuration and result valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_ACCEPT;
         mode_ff           <= MODE_IDLE;
         key_ff            <= KEY_IDLE;
         last_dit_ff       <= 1'b0;
         timer_ff          <= '0;
         play_slot_ff      <= '0;
         play_buf_ff       <= '0;
         play_len_ff       <= '0;
         play_idx_ff       <= '0;
         tone_on_ff        <= 1'b0;
         prompt_ff         <= '0;
         debounce_ff       <= '0;
         last_slot_ff      <= '0;
         rec_len_ff        <= '0;
         rec_buf_ff        <= NW'(SLOT_COUNT);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_len_ff[i] <= '0;
            slot_buf_ff[i] <= NW'(i);
         end
         save_timeout_ff   <= 16'd3000;
         debounce_ticks_ff <= 10'd50;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         key_ff       <= key_in;
         last_dit_ff  <= last_dit_in;
         timer_ff     <= timer_in;
         play_slot_ff <= play_slot_in;
         play_buf_ff  <= play_buf_in;
         play_len_ff  <= play_len_in;
         play_idx_ff  <= play_idx_in;
         tone_on_ff   <= tone_on_in;
         prompt_ff    <= prompt_in;
         debounce_ff  <= debounce_in;
         last_slot_ff <= last_slot_in;
         rec_len_ff   <= rec_len_in;
         rec_buf_ff   <= rec_buf_in;
         slot_len_ff  <= slot_len_in;
         slot_buf_ff  <= slot_buf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAVE_TIMEOUT: save_timeout_ff   <= csr_data;
               CSR_DEBOUNCE:     debounce_ticks_ff <= csr_data[DEBOUNCE_WIDTH-1:0];
               default:          save_timeout_ff   <= save_timeout_ff;
            endcase
         end
      end
   end

   // Payload registers without reset.
   always_ff @(posedge clock) begin
      dit_ff      <= dit_in;
      dah_ff      <= dah_in;
      rec_btn_ff  <= rec_btn_in;
      slots_ff    <= slots_in;
      unit_ff     <= unit_in;
      rsp_tone_ff <= rsp_tone_in;
      rsp_led_ff  <= rsp_led_in;
      rsp_mode_ff <= rsp_mode_in;
   end

endmodule

`default_nettype wire

// ===== rtl/mmk_checker.sv =====
// Port-level checks for the memory keyer, bound to its top level.
// Depends on mmk_pkg and morse_memory_keyer_unit.
`timescale 1ns / 1ps
`default_nettype none

module mmk_checker
   import mmk_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_tone,
   input wire logic       rsp_led,
   input wire logic [1:0] rsp_mode
);

   // A held result transaction keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_tone, rsp_led, rsp_mode}))
      else $error("result changed while stalled");

   // The lamp is lit exactly while recording.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_led == (rsp_mode == MODE_REC)))
      else $error("lamp does not match recording mode");

   // The save prompt is silent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mode == MODE_PROMPT |-> !rsp_tone)
      else $error("tone during save prompt");

   // No result is shown right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind morse_memory_keyer_unit mmk_checker u_mmk_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_tone  (rsp_ch.tone),
   .rsp_led   (rsp_ch.led),
   .rsp_mode  (rsp_ch.mode)
);

`default_nettype wire
